// File: rtl/bdq_pkg.sv
package bdq_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned DataW = 32;
  localparam int unsigned OpW   = 3;
  localparam int unsigned OccW  = 5;

  typedef enum logic [OpW-1:0] {
    OP_PUSH_LEFT  = 3'd0,
    OP_PUSH_RIGHT = 3'd1,
    OP_POP_LEFT   = 3'd2,
    OP_POP_RIGHT  = 3'd3,
    OP_PEEK_LEFT  = 3'd4,
    OP_SEARCH     = 3'd5
  } bdq_op_e;

  typedef struct packed {
    logic [OpW-1:0]     opcode;
    logic signed [31:0] value_in;
  } bdq_in_t;

  typedef struct packed {
    logic signed [31:0] value_out;
    logic               found;
    logic               was_empty;
    logic               push_dropped;
    logic [OccW-1:0]    occupancy;
  } bdq_out_t;

  // broadcast to every cell
  typedef struct packed {
    logic shift_right;  // push left: take left neighbor
    logic shift_left;   // pop left: take right neighbor
    logic search;       // compare against key
    logic capture;      // word accepted, latch tap and match
  } bdq_cell_ctrl_t;

endpackage

// File: rtl/bounded_deque_with_search.sv
// Bounded double-ended queue of signed 32-bit values with membership search.
// Input channel in_valid_i/in_ready_o carries one request word (opcode and
// value); output channel out_valid_o/out_ready_i returns exactly one result
// word per request: popped or peeked value, found, was_empty, push_dropped
// and the occupancy after the operation.
// Storage is a row of cells with the left end in cell 0. Push left shifts
// the row right, pop left shifts it left, push right loads the cell just past
// the tail, pop right only shortens the count. At acceptance each cell
// latches its tap value and its search match; the next cycle ORs the taps and
// matches of all cells into the result register.
// A request is accepted in S_IDLE, where the cells capture, and its result is
// registered in S_REDUCE; no new request is taken before the OR across the row.
// Reset empties the queue (count cleared, no result pending).
// When the receiver stalls, the result word holds in the output register and
// no new request is accepted until it is taken.
module bounded_deque_with_search (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bdq_pkg::bdq_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bdq_pkg::bdq_out_t out_data_o
);
  import bdq_pkg::*;

  typedef enum logic {S_IDLE, S_REDUCE} state_e;

  state_e          state_q;
  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  bdq_out_t        out_q;
  logic            was_empty_q, dropped_q;

  logic            accept, empty, full;
  logic            push_l, push_r, pop_l, pop_r, peek, search;
  bdq_cell_ctrl_t  ctrl;
  logic            was_empty_d, dropped_d;

  logic [DataW-1:0] cell_data [Depth];
  logic [DataW-1:0] cell_tap  [Depth];
  logic [Depth-1:0] cell_match;
  logic [DataW-1:0] tap_or;
  logic [CntW-1:0]  tail_idx;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign empty      = (count_q == '0);
  assign full       = (count_q == CntW'(Depth));
  assign tail_idx   = count_q - CntW'(1);

  always_comb begin
    push_l      = 1'b0;
    push_r      = 1'b0;
    pop_l       = 1'b0;
    pop_r       = 1'b0;
    peek        = 1'b0;
    search      = 1'b0;
    was_empty_d = 1'b0;
    dropped_d   = 1'b0;
    count_d     = count_q;
    case (in_data_i.opcode)
      OP_PUSH_LEFT: begin
        dropped_d = full;
        push_l    = !full;
      end
      OP_PUSH_RIGHT: begin
        dropped_d = full;
        push_r    = !full;
      end
      OP_POP_LEFT: begin
        was_empty_d = empty;
        pop_l       = !empty;
      end
      OP_POP_RIGHT: begin
        was_empty_d = empty;
        pop_r       = !empty;
      end
      OP_PEEK_LEFT: begin
        was_empty_d = empty;
        peek        = !empty;
      end
      OP_SEARCH: begin
        search = 1'b1;
      end
      default: begin
      end
    endcase
    if (push_l || push_r) begin
      count_d = count_q + CntW'(1);
    end else if (pop_l || pop_r) begin
      count_d = count_q - CntW'(1);
    end
  end

  assign ctrl.shift_right = accept && push_l;
  assign ctrl.shift_left  = accept && pop_l;
  assign ctrl.search      = search;
  assign ctrl.capture     = accept;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic [DataW-1:0] left_data, right_data;
    if (i == 0) begin : g_first
      assign left_data = in_data_i.value_in;
    end else begin : g_inner_l
      assign left_data = cell_data[i-1];
    end
    if (i == Depth - 1) begin : g_last
      assign right_data = cell_data[i];
    end else begin : g_inner_r
      assign right_data = cell_data[i+1];
    end

    bdq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .key_i       (in_data_i.value_in),
      .left_data_i (left_data),
      .right_data_i(right_data),
      .load_i      (accept && push_r && (count_q == CntW'(i))),
      .held_i      (CntW'(i) < count_q),
      .tap_sel_i   (((pop_l || peek) && (i == 0)) || (pop_r && (tail_idx == CntW'(i)))),
      .data_o      (cell_data[i]),
      .tap_o       (cell_tap[i]),
      .match_o     (cell_match[i])
    );
  end

  always_comb begin
    tap_or = '0;
    for (int i = 0; i < Depth; i++) begin
      tap_or = tap_or | cell_tap[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      was_empty_q <= 1'b0;
      dropped_q   <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (out_valid_q && out_ready_i) begin
            out_valid_q <= 1'b0;
          end
          if (accept) begin
            count_q     <= count_d;
            was_empty_q <= was_empty_d;
            dropped_q   <= dropped_d;
            state_q     <= S_REDUCE;
          end
        end
        S_REDUCE: begin
          out_q.value_out    <= tap_or;
          out_q.found        <= |cell_match;
          out_q.was_empty    <= was_empty_q;
          out_q.push_dropped <= dropped_q;
          out_q.occupancy    <= OccW'(count_q);
          out_valid_q        <= 1'b1;
          state_q            <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/bdq_cell.sv
module bdq_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bdq_pkg::bdq_cell_ctrl_t      ctrl_i,
  input  logic [bdq_pkg::DataW-1:0]    key_i,
  input  logic [bdq_pkg::DataW-1:0]    left_data_i,
  input  logic [bdq_pkg::DataW-1:0]    right_data_i,
  input  logic                         load_i,
  input  logic                         held_i,
  input  logic                         tap_sel_i,
  output logic [bdq_pkg::DataW-1:0]    data_o,
  output logic [bdq_pkg::DataW-1:0]    tap_o,
  output logic                         match_o
);
  import bdq_pkg::*;

  logic [DataW-1:0] data_q, data_d;
  logic [DataW-1:0] tap_q;
  logic             match_q;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.shift_right) begin
      data_d = left_data_i;
    end else if (ctrl_i.shift_left) begin
      data_d = right_data_i;
    end else if (load_i) begin
      data_d = key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    if (ctrl_i.capture) begin
      tap_q <= tap_sel_i ? data_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.capture) begin
      match_q <= ctrl_i.search && held_i && (data_q == key_i);
    end
  end

  assign data_o  = data_q;
  assign tap_o   = tap_q;
  assign match_o = match_q;

endmodule
